// ===== hdl/pwba_pkg.sv =====
// Shared types and constants for the proof-of-work block checker.
// SHA-256 round constants, initial hash values and the queued item type.
// No dependencies.
package pwba_pkg;

  localparam int unsigned CfgW = 9;

  typedef struct packed {
    logic        first;
    logic        last;
    logic        valid;
    logic [7:0]  data;
    logic [63:0] nonce;
  } item_t;

  typedef logic [7:0][31:0] hvec_t;

  localparam hvec_t InitH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/pwba_front.sv =====
// Front end: accepts input beats, marks the first beat of each block and
// queues them for the hashing back end. Uses pwba_pkg.
module pwba_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [71:0]         s_tdata,   // nonce[63:0], payload_byte[71:64]
  input  logic                s_tuser,   // byte_valid
  input  logic                s_tlast,
  output logic                head_valid,
  output pwba_pkg::item_t     head,
  input  logic                pop
);
  import pwba_pkg::*;

  localparam int unsigned Depth = 4;

  item_t       q [Depth];
  logic [1:0]  wptr, rptr;
  logic [2:0]  count;
  logic        in_block;
  logic        push;

  assign s_tready   = (count != 3'(Depth));
  assign push       = s_tvalid && s_tready;
  assign head_valid = (count != 3'd0);
  assign head       = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= '{first: !in_block, last: s_tlast, valid: s_tuser,
                   data: s_tdata[71:64], nonce: s_tdata[63:0]};
    end
    if (rst) begin
      wptr     <= '0;
      rptr     <= '0;
      count    <= '0;
      in_block <= 1'b0;
    end else begin
      if (push) begin
        wptr     <= wptr + 2'd1;
        in_block <= !s_tlast;
      end
      if (pop) rptr <= rptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

// ===== hdl/pwba_back.sv =====
// Back end: byte sequencer, SHA-256 round unit (one round per cycle),
// target check and result register. Uses pwba_pkg.
module pwba_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [8:0]          target_bits,
  input  logic                head_valid,
  input  pwba_pkg::item_t     head,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [319:0]        m_tdata,
  output logic                m_tuser
);
  import pwba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_HDR, S_PAY, S_PREV, S_PAD80, S_PADZ, S_LEN, S_COMP, S_ADD,
    S_CHECK, S_OUT
  } state_t;

  state_t       st, ret, st_next;
  logic [4:0]   cnt, cnt_next;
  logic [5:0]   rnd;
  hvec_t        h, v, prev;
  logic [511:0] msg;
  logic [63:0]  len, bitlen, idx, nonce;
  logic         ok;
  logic         absorb;
  logic [7:0]   abyte;
  logic [6:0]   len_lo_next;

  // round datapath
  logic [31:0] w0, w1, w9, w14, wnew, s0, s1, e1, ch, a0, mj, t1, t2;
  logic [31:0] cw, mask;
  logic [2:0]  ci;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign w0   = msg[511:480];
  assign w1   = msg[479:448];
  assign w9   = msg[223:192];
  assign w14  = msg[63:32];
  assign s0   = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1   = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign wnew = w0 + s0 + w9 + s1;
  assign e1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
  assign ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1   = v[7] + e1 + ch + round_k(rnd) + w0;
  assign a0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
  assign mj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2   = a0 + mj;

  assign len_lo_next = {1'b0, len[5:0]} + 7'd1;

  // one digest word per check cycle; target of 256 or more covers every word
  assign ci = cnt[2:0];
  assign cw = h[ci];
  always_comb begin
    if (target_bits >= ({1'b0, ci, 5'd0} + 9'd32)) begin
      mask = '1;
    end else if (target_bits <= {1'b0, ci, 5'd0}) begin
      mask = '0;
    end else begin
      mask = ~(32'hffffffff >> target_bits[4:0]);
    end
  end

  assign pop = (st == S_PAY);

  always_comb begin
    st_next  = st;
    cnt_next = cnt;
    absorb   = 1'b0;
    abyte    = '0;
    case (st)
      S_HDR: begin
        absorb = 1'b1;
        abyte  = cnt[3] ? nonce[8*cnt[2:0] +: 8] : idx[8*cnt[2:0] +: 8];
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd15) begin
          st_next  = S_PAY;
          cnt_next = '0;
        end
      end
      S_PAY: begin
        absorb  = head.valid;
        abyte   = head.data;
        st_next = head.last ? S_PREV : S_IDLE;
      end
      S_PREV: begin
        absorb   = 1'b1;
        abyte    = prev[cnt[4:2]][8*(3 - cnt[1:0]) +: 8];
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) begin
          st_next  = S_PAD80;
          cnt_next = '0;
        end
      end
      S_PAD80, S_PADZ: begin
        absorb  = 1'b1;
        abyte   = (st == S_PAD80) ? 8'h80 : 8'h00;
        st_next = (len_lo_next[5:0] == 6'd56) ? S_LEN : S_PADZ;
      end
      S_LEN: begin
        absorb   = 1'b1;
        abyte    = bitlen[8*(7 - cnt[2:0]) +: 8];
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd7) begin
          st_next  = S_CHECK;
          cnt_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      ret      <= S_IDLE;
      cnt      <= '0;
      rnd      <= '0;
      h        <= InitH;
      prev     <= '0;
      idx      <= '0;
      len      <= '0;
      ok       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      cnt <= cnt_next;
      st  <= st_next;
      if (absorb) begin
        msg <= {msg[503:0], abyte};
        len <= len + 64'd1;
        if (len[5:0] == 6'd63) begin
          st  <= S_COMP;
          ret <= st_next;
          rnd <= '0;
          v   <= h;
        end
      end
      case (st)
        S_IDLE: begin
          if (head_valid) begin
            st <= S_PAY;
            if (head.first) begin
              st    <= S_HDR;
              h     <= InitH;
              len   <= '0;
              nonce <= head.nonce;
              cnt   <= '0;
            end
          end
        end
        S_PAD80: bitlen <= {len[60:0], 3'b000};
        S_LEN:   ok <= 1'b1;
        S_COMP: begin
          msg <= {msg[479:0], wnew};
          v   <= {v[6], v[5], v[4], v[3] + t1, v[2], v[1], v[0], t1 + t2};
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) st <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          st <= ret;
        end
        S_CHECK: begin
          if ((cw & mask) != 32'd0) ok <= 1'b0;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd7) begin
            st  <= S_OUT;
            cnt <= '0;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= ok;
            m_tdata  <= {h[6], h[7], h[4], h[5], h[2], h[3], h[0], h[1], idx};
            if (ok) begin
              prev <= h;
              idx  <= idx + 64'd1;
            end
            st <= S_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/proof_of_work_block_append_top.sv =====
// Proof-of-work block checker: chained SHA-256 over index, nonce, payload
// and previous digest. Uses pwba_pkg, pwba_front, pwba_back.
// Each payload beat passes through the idle and payload states; each 64-byte chunk
// then takes 64 rounds and the add.
// Per block: 16 header bytes; at the end 32 digest bytes, 1 to 64 pad and 8 length
// bytes, one or two chunks, 8 word checks and output. Sync rst clears state, not data.
module proof_of_work_block_append_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [8:0]    cfg_wdata,  // target_bits
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [71:0]   s_tdata,    // nonce[63:0], payload_byte[71:64]
  input  logic          s_tuser,    // byte_valid
  input  logic          s_tlast,    // last
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [319:0]  m_tdata,    // digest words 6,7,4,5,2,3,0,1 from the top, block_index[63:0]
  output logic          m_tuser     // accepted
);
  import pwba_pkg::*;

  logic [CfgW-1:0] target_bits;
  logic            head_valid, pop;
  item_t           head;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_bits <= '0;
    end else if (cfg_we) begin
      target_bits <= cfg_wdata;
    end
  end

  pwba_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .head_valid, .head, .pop
  );

  pwba_back u_back (
    .clk, .rst, .target_bits, .head_valid, .head, .pop,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

endmodule
